// File: rtl/sliding_window_max_core_assert.svh
// Assertion macros shared by the sliding window maximum checker.
`ifndef SLIDING_WINDOW_MAX_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MAX_CORE_ASSERT_SVH

// Concurrent assertion on clk_i, off while rst_ni is low.
`define SWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A stalled request keeps valid high and its payload unchanged.
`define SWM_ASSERT_HOLD(lbl, vld, stl, data, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && stl) |=> (vld && $stable(data))) \
    else $error(msg);

`endif

// File: rtl/swm_pkg.sv
// Shared types and constants of the sliding window maximum block.
package swm_pkg;

  localparam int unsigned CfgWindowW = 7;
  localparam int unsigned PaddrW     = 3;
  localparam int unsigned PdataW     = 32;

  localparam logic [CfgWindowW-1:0] WindowReset = 7'd3;
  localparam logic                  RegWindow   = 1'b0;

  typedef struct packed {
    logic load;
    logic rd_back;
    logic rd_front;
    logic drop_back;
    logic drop_front;
    logic keep_front;
    logic append;
  } swm_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic back_le;
    logic front_old;
    logic out_free;
  } swm_sts_t;

endpackage

// File: rtl/sliding_window_max_core.sv
// A request is taken only while idle; the block then compares it against the queued candidates,
// dropping back candidates that are not greater, then front candidates that have left the window,
// and appends it. It takes no new request until the append; the candidate memory is read once
// per candidate compared, back drops first, then front drops. A stalled result holds the append.
// Reset: queue empty, fill and position counters zero, window_length 3; the candidate
// memory is not cleared and is only read where written.
module sliding_window_max_core #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]     sample_i,
  input  logic                              restart_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]     window_max_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swm_pkg::PaddrW-1:0]        paddr,
  input  logic [swm_pkg::PdataW-1:0]        pwdata,
  output logic [swm_pkg::PdataW-1:0]        prdata,
  output logic                              pready
);
  import swm_pkg::*;

  logic [CfgWindowW-1:0] window_length_q;
  logic                  reg_hit;
  swm_cmd_t              cmd;
  swm_sts_t              sts;

  assign reg_hit = (paddr[PaddrW-1:2] == RegWindow);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? PdataW'(window_length_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= WindowReset;
    end else if (psel && penable && pwrite && reg_hit) begin
      window_length_q <= pwdata[CfgWindowW-1:0];
    end
  end

  swm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  swm_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_i        (sample_i),
    .restart_i       (restart_i),
    .window_length_i (window_length_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .window_max_o    (window_max_o)
  );

endmodule

// File: rtl/swm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/swm_ctrl.sv
// Sequencer for the candidate queue: back drops, front drops, append.
module swm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  swm_pkg::swm_sts_t sts_i,
  output swm_pkg::swm_cmd_t cmd_o
);
  import swm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_BACK_RD   = 5'b00010,
    S_BACK_CMP  = 5'b00100,
    S_FRONT_CMP = 5'b01000,
    S_APPEND    = 5'b10000
  } swm_state_e;

  swm_state_e state_q, state_d;
  swm_cmd_t   cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_BACK_RD;
        end
      end
      S_BACK_RD: begin
        if (sts_i.count_zero) begin
          state_d = S_APPEND;
        end else begin
          cmd.rd_back = 1'b1;
          state_d     = S_BACK_CMP;
        end
      end
      S_BACK_CMP: begin
        if (sts_i.back_le) begin
          cmd.drop_back = 1'b1;
          if (sts_i.count_one) begin
            state_d = S_APPEND;
          end else begin
            cmd.rd_back = 1'b1;
          end
        end else begin
          cmd.rd_front = 1'b1;
          state_d      = S_FRONT_CMP;
        end
      end
      S_FRONT_CMP: begin
        if (sts_i.front_old) begin
          cmd.drop_front = 1'b1;
          if (sts_i.count_one) begin
            state_d = S_APPEND;
          end else begin
            cmd.rd_front = 1'b1;
          end
        end else begin
          cmd.keep_front = 1'b1;
          state_d        = S_APPEND;
        end
      end
      S_APPEND: begin
        if (sts_i.out_free) begin
          cmd.append = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o      = cmd;
  assign in_stall_o = (state_q != S_IDLE);

endmodule

// File: rtl/swm_dp.sv
// Datapath: candidate memory, queue pointers, counters and result register.
module swm_dp #(
  parameter int unsigned SAMPLE_BITS = 32,
  parameter int unsigned MAX_WINDOW  = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [SAMPLE_BITS-1:0]         sample_i,
  input  logic                                  restart_i,
  input  logic [swm_pkg::CfgWindowW-1:0]        window_length_i,
  input  swm_pkg::swm_cmd_t                     cmd_i,
  output swm_pkg::swm_sts_t                     sts_o,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]         window_max_o
);
  import swm_pkg::*;

  localparam int unsigned IdxW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CntW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam int unsigned MemW = SAMPLE_BITS + CntW;

  function automatic logic [IdxW-1:0] slot_of(logic [IdxW-1:0] head, logic [CntW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(head) + SumW'(off);
    if (sum >= SumW'(MAX_WINDOW)) begin
      sum = sum - SumW'(MAX_WINDOW);
    end
    return IdxW'(sum);
  endfunction

  logic signed [SAMPLE_BITS-1:0] sample_q, front_q, window_max_q, window_max_d, result;
  logic        [CntW-1:0]        w_q, w_eff, count_q, count_d, pos_q, pos_d, fill_q, fill_d;
  logic        [CntW-1:0]        age;
  logic        [IdxW-1:0]        head_q, head_d, rd_addr, wr_addr;
  logic        [MemW-1:0]        rd_data;
  logic signed [SAMPLE_BITS-1:0] rd_value;
  logic        [CntW-1:0]        rd_pos;
  logic        [31:0]            wl_ext;
  logic                          out_valid_q, out_valid_d, out_load;

  always_comb begin
    wl_ext = 32'(window_length_i);
    if (wl_ext == 32'd0) begin
      w_eff = CntW'(1);
    end else if (wl_ext > 32'(MAX_WINDOW)) begin
      w_eff = CntW'(MAX_WINDOW);
    end else begin
      w_eff = CntW'(wl_ext);
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    fill_d  = fill_q;
    pos_d   = pos_q;
    if (cmd_i.load && restart_i) begin
      head_d  = '0;
      count_d = '0;
      fill_d  = '0;
    end
    if (cmd_i.drop_back) begin
      count_d = count_q - CntW'(1);
    end
    if (cmd_i.drop_front) begin
      head_d  = slot_of(head_q, CntW'(1));
      count_d = count_q - CntW'(1);
    end
    if (cmd_i.append) begin
      count_d = count_q + CntW'(1);
      pos_d   = pos_q + CntW'(1);
      if (fill_q < CntW'(MAX_WINDOW)) begin
        fill_d = fill_q + CntW'(1);
      end
    end
  end

  assign rd_addr  = cmd_i.rd_front ? slot_of(head_d, '0) : slot_of(head_d, count_d - CntW'(1));
  assign wr_addr  = slot_of(head_q, count_q);
  assign rd_value = rd_data[SAMPLE_BITS-1:0];
  assign rd_pos   = rd_data[MemW-1:SAMPLE_BITS];
  assign age      = pos_q - rd_pos;

  swm_ram #(
    .Width (MemW),
    .Depth (MAX_WINDOW)
  ) u_cand_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (wr_addr),
    .wdata_i ({pos_q, sample_q}),
    .re_i    (cmd_i.rd_back | cmd_i.rd_front),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.count_one  = (count_q == CntW'(1));
  assign sts_o.back_le    = (rd_value <= sample_q);
  assign sts_o.front_old  = (age >= w_q);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign result   = (count_q == '0) ? sample_q : front_q;
  assign out_load = cmd_i.append && (fill_d >= w_q);

  always_comb begin
    out_valid_d  = out_valid_q && out_stall_i;
    window_max_d = window_max_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      window_max_d = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      fill_q      <= '0;
      pos_q       <= '0;
      w_q         <= CntW'(1);
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      fill_q      <= fill_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.load) begin
        w_q <= w_eff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
    end
    if (cmd_i.keep_front) begin
      front_q <= rd_value;
    end
    window_max_q <= window_max_d;
  end

  assign out_valid_o  = out_valid_q;
  assign window_max_o = window_max_q;

endmodule

// File: rtl/swm_chk.sv
// Port-level checker for the sliding window maximum block, with its bind.
`include "sliding_window_max_core_assert.svh"

module swm_chk #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS-1:0] window_max_o
);

  `SWM_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "accepted request did not make the block busy")
  `SWM_ASSERT(a_result_from_busy, $rose(out_valid_o) |-> $past(in_stall_o), "result appeared while the block was idle")
  `SWM_ASSERT_HOLD(a_out_hold, out_valid_o, out_stall_i, window_max_o, "stalled result changed")

endmodule

bind sliding_window_max_core swm_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_swm_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .window_max_o (window_max_o)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sliding window maximum core: directed and random requests, APB window setup.
module tb_top;
  import swm_pkg::*;

  localparam int unsigned MaxWindow     = 64;
  localparam int unsigned SampleBits    = 32;
  localparam int unsigned GapMax        = 13;
  localparam int unsigned DrainCycles   = 100;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned ReportLimit   = 10;
  localparam int unsigned PhaseCount    = 13;

  localparam logic [PaddrW-1:0] WindowAddr = PaddrW'(4 * RegWindow);

  typedef logic signed [SampleBits-1:0] sample_t;

  localparam sample_t SampleMin = sample_t'(32'h8000_0000);
  localparam sample_t SampleMax = sample_t'(32'h7fff_ffff);

  typedef struct {
    sample_t value;
    logic    restart;
  } req_t;

  typedef struct {
    sample_t    value;
    logic [7:0] pos;
  } cand_t;

  typedef enum int unsigned {
    PickAny,
    PickNarrow,
    PickFall,
    PickRise,
    PickEdge
  } pick_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  sample_t             sample_i    = '0;
  logic                restart_i   = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  sample_t             window_max_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [PaddrW-1:0]   paddr       = '0;
  logic [PdataW-1:0]   pwdata      = '0;
  logic [PdataW-1:0]   prdata;
  logic                pready;

  // window maximum predictor state
  cand_t               cand_q[$];
  logic [7:0]          arrival_pos = '0;
  logic [6:0]          fill_cnt    = '0;
  logic [CfgWindowW-1:0] win_len   = WindowReset;
  sample_t             max_expected[$];
  sample_t             exp_max;

  req_t                pending[$];
  req_t                cur_req     = '{'0, 1'b0};
  logic                req_busy    = 1'b0;
  int unsigned         reqs_sent     = 0;
  int unsigned         reqs_taken    = 0;
  int unsigned         results_taken = 0;
  int unsigned         results_seen  = 0;
  int unsigned         gap_left      = 0;
  int unsigned         stall_left    = 0;
  int unsigned         in_gap_max    = 0;
  int unsigned         out_stall_max = 0;
  int unsigned         activity      = 0;
  int unsigned         failures      = 0;

  sliding_window_max_core #(
    .MAX_WINDOW  (MaxWindow),
    .SAMPLE_BITS (SampleBits)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .window_max_o (window_max_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void report_failure(input string what);
    failures++;
    if (failures <= ReportLimit) begin
      $display("mismatch: %s", what);
    end
  endfunction

  function automatic void add_req(input sample_t value, input logic restart);
    req_t rq;
    rq.value   = value;
    rq.restart = restart;
    pending.insert(pending.size(), rq);
  endfunction

  function automatic void track_window_max(input sample_t s, input logic restart);
    int unsigned span;
    logic [7:0]  age;
    cand_t       c;
    span = (win_len == 0) ? 1 : ((win_len > MaxWindow) ? MaxWindow : win_len);
    if (restart) begin
      cand_q.delete();
      fill_cnt = '0;
    end
    while (cand_q.size() > 0 && cand_q[cand_q.size()-1].value <= s) begin
      cand_q.delete(cand_q.size() - 1);
    end
    while (cand_q.size() > 0) begin
      age = arrival_pos - cand_q[0].pos;
      if (age < span) break;
      cand_q.delete(0);
    end
    if (cand_q.size() >= MaxWindow) begin
      cand_q.delete(0);
    end
    c.value = s;
    c.pos   = arrival_pos;
    cand_q.insert(cand_q.size(), c);
    arrival_pos++;
    if (fill_cnt < MaxWindow) begin
      fill_cnt++;
    end
    if (fill_cnt >= span) begin
      max_expected.insert(max_expected.size(), cand_q[0].value);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        track_window_max(sample_i, restart_i);
        reqs_taken++;
        activity++;
      end
      if (out_valid_o && !out_stall_i) begin
        results_taken++;
        activity++;
        if (max_expected.size() == 0) begin
          report_failure($sformatf("window_max %0d with no result expected", window_max_o));
        end else begin
          exp_max = max_expected[0];
          max_expected.delete(0);
          if (window_max_o !== exp_max) begin
            report_failure($sformatf("window_max expected %0d got %0d", exp_max,
                                     window_max_o));
          end
        end
      end
      if (psel && penable && pready) begin
        activity++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_busy && reqs_taken == reqs_sent) begin
        req_busy = 1'b0;
        gap_left = $urandom_range(0, in_gap_max);
      end
      if (!req_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          cur_req  = pending[0];
          pending.delete(0);
          req_busy = 1'b1;
          reqs_sent++;
        end
      end
      in_valid_i <= req_busy;
      sample_i   <= cur_req.value;
      restart_i  <= cur_req.restart;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (results_taken != results_seen) begin
        results_seen = results_taken;
        stall_left   = $urandom_range(0, out_stall_max);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic cfg_access(input logic write, input logic [PdataW-1:0] wdata,
                            output logic [PdataW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= WindowAddr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (write) begin
      win_len = wdata[CfgWindowW-1:0];
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_window(input logic [CfgWindowW-1:0] value);
    logic [PdataW-1:0] rd;
    cfg_access(1'b1, PdataW'(value), rd);
    cfg_access(1'b0, '0, rd);
    if (rd[CfgWindowW-1:0] !== value) begin
      report_failure($sformatf("window_length readback expected %0d got %0d", value,
                               rd[CfgWindowW-1:0]));
    end
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (pending.size() != 0 || reqs_sent != reqs_taken || max_expected.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic queue_random(input int unsigned n, input logic lead_restart);
    sample_t     s;
    pick_e       style;
    int unsigned run;
    logic        rs;
    s     = '0;
    run   = 0;
    style = PickAny;
    for (int unsigned i = 0; i < n; i++) begin
      if (run == 0) begin
        style = pick_e'($urandom_range(0, 4));
        run   = (style == PickFall) ? $urandom_range(1, 70) : $urandom_range(1, 24);
      end
      run--;
      case (style)
        PickAny: begin
          s = sample_t'($urandom);
        end
        PickNarrow: begin
          s = sample_t'($urandom_range(0, 8)) - 4;
        end
        PickFall: begin
          s = s - sample_t'($urandom_range(0, 3));
        end
        PickRise: begin
          s = s + sample_t'($urandom_range(0, 3));
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       s = SampleMin;
            1:       s = SampleMax;
            2:       s = '0;
            default: s = '1;
          endcase
        end
      endcase
      rs = (i == 0) ? lead_restart : ($urandom_range(0, 79) == 0);
      add_req(s, rs);
    end
  endtask

  initial begin : watchdog
    int unsigned quiet;
    int unsigned last_activity;
    quiet         = 0;
    last_activity = 0;
    while (quiet < WatchdogLimit) begin
      @(negedge clk_i);
      if (activity != last_activity) begin
        last_activity = activity;
        quiet         = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    logic [CfgWindowW-1:0] settings [PhaseCount];
    int unsigned           span;
    int unsigned           n;
    settings = '{7'd127, 7'd2, 7'd64, 7'd1, 7'd9, 7'd4, 7'd64, 7'd33, 7'd0, 7'd17,
                 7'd3, 7'd50, 7'd6};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    in_gap_max    = 3;
    out_stall_max = 3;
    add_req(sample_t'(0), 1'b1);
    add_req(SampleMax, 1'b0);
    add_req(SampleMin, 1'b0);
    add_req(SampleMin, 1'b0);
    add_req(sample_t'(-1), 1'b0);
    add_req(sample_t'(-1), 1'b0);
    add_req(sample_t'(0), 1'b0);
    add_req(SampleMax, 1'b0);
    add_req(SampleMax, 1'b0);
    add_req(sample_t'(1), 1'b1);
    add_req(sample_t'(2), 1'b0);
    add_req(sample_t'(3), 1'b0);
    add_req(sample_t'(-5), 1'b0);
    add_req(sample_t'(-6), 1'b0);
    add_req(sample_t'(-7), 1'b0);
    add_req(sample_t'(-7), 1'b1);
    settle();

    set_window('0);
    add_req(SampleMin, 1'b0);
    add_req(SampleMax, 1'b0);
    add_req(sample_t'(5), 1'b1);
    add_req(SampleMin, 1'b0);
    settle();

    for (int unsigned k = 0; k < PhaseCount; k++) begin
      set_window(settings[k]);
      span = (settings[k] == 0) ? 1 :
             ((settings[k] > MaxWindow) ? MaxWindow : settings[k]);
      n    = 30 + span + $urandom_range(0, 20);
      case (k % 4)
        0: begin
          in_gap_max    = 0;
          out_stall_max = 0;
        end
        1: begin
          in_gap_max    = GapMax;
          out_stall_max = 0;
        end
        2: begin
          in_gap_max    = 0;
          out_stall_max = GapMax;
        end
        default: begin
          in_gap_max    = GapMax;
          out_stall_max = GapMax;
        end
      endcase
      queue_random(n, (k % 3) == 0);
      settle();
    end

    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
